### hw/rtl/nearest_key_position_cache_macros.svh
// assertion macros for the nearest key position cache
// no dependencies; included by the modules that check their own logic
`ifndef NEAREST_KEY_POSITION_CACHE_MACROS_SVH
`define NEAREST_KEY_POSITION_CACHE_MACROS_SVH

// same-cycle implication under reset
`define NKPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define NKPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/nkpc_pkg.sv
// shared types and constants for the nearest key position cache
// no dependencies; used by nkpc_cell, nkpc_pick and the top level
package nkpc_pkg;

    localparam int KEY_W = 32;
    localparam int POS_W = 40;
    localparam int WIN_W = 16;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd10;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    // running search state carried from cell to cell
    typedef struct packed {
        logic signed [KEY_W-1:0] query;
        logic                    have_lo;
        logic signed [KEY_W-1:0] lo_key;
        logic [POS_W-1:0]        lo_pos;
        logic                    have_hi;
        logic signed [KEY_W-1:0] hi_key;
        logic [POS_W-1:0]        hi_pos;
    } scan_t;

endpackage

### hw/rtl/nkpc_cell.sv
// one cache cell: holds one entry and updates the passing search state
// depends on nkpc_pkg
module nkpc_cell
    import nkpc_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 5
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CNT_W-1:0]        fill_count,
    input  logic                    wr_en,
    input  logic signed [KEY_W-1:0] wr_key,
    input  logic [POS_W-1:0]        wr_pos,
    input  logic                    scan_in_vld,
    input  scan_t                   scan_in,
    output logic                    scan_out_vld,
    output scan_t                   scan_out
);

    logic signed [KEY_W-1:0] key_reg;
    logic [POS_W-1:0]        pos_reg;
    logic                    vld_reg;
    scan_t                   scan_reg;
    scan_t                   scan_next;
    logic                    entry_used;

    assign entry_used = fill_count > CNT_W'(CELL_INDEX);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg <= wr_key;
            pos_reg <= wr_pos;
        end
    end

    always_comb
    begin
        scan_next = scan_in;
        if (entry_used)
        begin
            if (key_reg <= scan_in.query)
            begin
                if (!scan_in.have_lo || key_reg > scan_in.lo_key)
                begin
                    scan_next.have_lo = 1'b1;
                    scan_next.lo_key  = key_reg;
                    scan_next.lo_pos  = pos_reg;
                end
            end
            else
            begin
                if (!scan_in.have_hi || key_reg < scan_in.hi_key)
                begin
                    scan_next.have_hi = 1'b1;
                    scan_next.hi_key  = key_reg;
                    scan_next.hi_pos  = pos_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= scan_in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_in_vld)
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out_vld = vld_reg;
    assign scan_out     = scan_reg;

endmodule

### hw/rtl/nkpc_pick.sv
// chooses the lower or upper entry at the end of the cell row and holds the item
// depends on nkpc_pkg; drives the result channel of the top level
module nkpc_pick
    import nkpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [WIN_W-1:0]        near_window,
    input  logic                    scan_vld,
    input  scan_t                   scan,
    output logic                    pend_busy,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic                    found,
    output logic signed [KEY_W-1:0] match_time,
    output logic [POS_W-1:0]        match_position
);

    logic [KEY_W:0]          below;
    logic [KEY_W:0]          above;
    logic                    pick_hi;
    logic                    sel_found;
    logic signed [KEY_W-1:0] sel_time;
    logic [POS_W-1:0]        sel_pos;

    logic                    pend_vld_reg;
    logic                    pend_vld_next;
    logic                    pend_found_reg;
    logic signed [KEY_W-1:0] pend_time_reg;
    logic [POS_W-1:0]        pend_pos_reg;

    logic                    out_vld_reg;
    logic                    out_vld_next;
    logic                    out_found_reg;
    logic signed [KEY_W-1:0] out_time_reg;
    logic [POS_W-1:0]        out_pos_reg;
    logic                    load_out;

    // both distances are non-negative at 33 bits
    assign below = {scan.query[KEY_W-1], scan.query} - {scan.lo_key[KEY_W-1], scan.lo_key};
    assign above = {scan.hi_key[KEY_W-1], scan.hi_key} - {scan.query[KEY_W-1], scan.query};

    always_comb
    begin
        pick_hi   = 1'b0;
        sel_found = scan.have_lo | scan.have_hi;
        if (scan.have_hi)
        begin
            if (!scan.have_lo)
            begin
                pick_hi = 1'b1;
            end
            else if (below > {{(KEY_W+1-WIN_W){1'b0}}, near_window} && above < below)
            begin
                pick_hi = 1'b1;
            end
        end
        if (!sel_found)
        begin
            sel_time = '0;
            sel_pos  = '0;
        end
        else if (pick_hi)
        begin
            sel_time = scan.hi_key;
            sel_pos  = scan.hi_pos;
        end
        else
        begin
            sel_time = scan.lo_key;
            sel_pos  = scan.lo_pos;
        end
    end

    assign load_out = pend_vld_reg && (!out_vld_reg || !result_stall);

    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        if (scan_vld)
        begin
            pend_vld_next = 1'b1;
        end
        else if (load_out)
        begin
            pend_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_vld)
        begin
            pend_found_reg <= sel_found;
            pend_time_reg  <= sel_time;
            pend_pos_reg   <= sel_pos;
        end
        if (load_out)
        begin
            out_found_reg <= pend_found_reg;
            out_time_reg  <= pend_time_reg;
            out_pos_reg   <= pend_pos_reg;
        end
    end

    assign pend_busy      = pend_vld_reg;
    assign result_valid   = out_vld_reg;
    assign found          = out_found_reg;
    assign match_time     = out_time_reg;
    assign match_position = out_pos_reg;

endmodule

### hw/rtl/nearest_key_position_cache.sv
// top level of the nearest key position cache: cell row, put control, window register
// depends on nkpc_pkg, nkpc_cell, nkpc_pick and nearest_key_position_cache_macros.svh
//
// A put writes the next free cell when it is taken, or once all cells are
// filled the cell under the round-robin pointer; it gives no item back. A get sends
// its query down the row of CACHE_ENTRIES cells, one cell per cycle, each cell
// refining the best lower and upper entry; a final stage picks the entry, holds it in
// a pending register and moves it to the output register, which drives the result channel.
// While a get is in the row or its pick waits for the output stage, cmd_stall is high.
// No clearing pass follows reset; cells beyond the fill count are never consulted.
`include "nearest_key_position_cache_macros.svh"

module nearest_key_position_cache
    import nkpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [WIN_W-1:0]        cfg_wr_data,
    input  logic                    cmd_valid,
    output logic                    cmd_stall,
    input  logic                    cmd,
    input  logic signed [KEY_W-1:0] key_time,
    input  logic [POS_W-1:0]        file_position,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic                    found,
    output logic signed [KEY_W-1:0] match_time,
    output logic [POS_W-1:0]        match_position
);

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [WIN_W-1:0]   window_reg;
    logic [CNT_W-1:0]   fill_count_reg;
    logic [CNT_W-1:0]   fill_count_next;
    logic [IDX_W-1:0]   replace_ptr_reg;
    logic [IDX_W-1:0]   replace_ptr_next;
    logic [IDX_W-1:0]   slot;
    logic               table_full;
    logic               cmd_accept;
    logic               put_accept;
    logic               get_accept;
    logic               pend_busy;
    logic [CACHE_ENTRIES:0] scan_vld;
    scan_t              scan_bus [CACHE_ENTRIES+1];

    assign cmd_accept = cmd_valid && !cmd_stall;
    assign put_accept = cmd_accept && (cmd == CMD_PUT);
    assign get_accept = cmd_accept && (cmd == CMD_GET);
    assign cmd_stall  = (|scan_vld[CACHE_ENTRIES:1]) || pend_busy;

    assign table_full = fill_count_reg == CNT_W'(CACHE_ENTRIES);
    assign slot       = table_full ? replace_ptr_reg : fill_count_reg[IDX_W-1:0];

    always_comb
    begin
        fill_count_next  = fill_count_reg;
        replace_ptr_next = replace_ptr_reg;
        if (put_accept)
        begin
            if (!table_full)
            begin
                fill_count_next = fill_count_reg + 1'b1;
            end
            else if (replace_ptr_reg == IDX_W'(CACHE_ENTRIES - 1))
            begin
                replace_ptr_next = '0;
            end
            else
            begin
                replace_ptr_next = replace_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= WINDOW_RESET;
            fill_count_reg  <= '0;
            replace_ptr_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
            fill_count_reg  <= fill_count_next;
            replace_ptr_reg <= replace_ptr_next;
        end
    end

    // query launch into the first cell
    assign scan_vld[0]         = get_accept;
    assign scan_bus[0].query   = key_time;
    assign scan_bus[0].have_lo = 1'b0;
    assign scan_bus[0].lo_key  = '0;
    assign scan_bus[0].lo_pos  = '0;
    assign scan_bus[0].have_hi = 1'b0;
    assign scan_bus[0].hi_key  = '0;
    assign scan_bus[0].hi_pos  = '0;

    for (genvar i = 0; i < CACHE_ENTRIES; i++)
    begin : g_cell
        nkpc_cell #(
            .CELL_INDEX (i),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .fill_count   (fill_count_reg),
            .wr_en        (put_accept && (slot == IDX_W'(i))),
            .wr_key       (key_time),
            .wr_pos       (file_position),
            .scan_in_vld  (scan_vld[i]),
            .scan_in      (scan_bus[i]),
            .scan_out_vld (scan_vld[i+1]),
            .scan_out     (scan_bus[i+1])
        );
    end

    nkpc_pick u_pick (
        .clk            (clk),
        .rst_n          (rst_n),
        .near_window    (window_reg),
        .scan_vld       (scan_vld[CACHE_ENTRIES]),
        .scan           (scan_bus[CACHE_ENTRIES]),
        .pend_busy      (pend_busy),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .found          (found),
        .match_time     (match_time),
        .match_position (match_position)
    );

    // at most one get in the row or waiting for the output stage
    `NKPC_ASSERT_IMPL(a_one_get, clk, rst_n, 1'b1, $onehot0({scan_vld[CACHE_ENTRIES:1], pend_busy}), "more than one get in flight")
    `NKPC_ASSERT_NEXT(a_get_blocks, clk, rst_n, get_accept, cmd_stall, "get taken without blocking the next item")
    `NKPC_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_count_reg <= CNT_W'(CACHE_ENTRIES), "fill count past table size")
    `NKPC_ASSERT_IMPL(a_ptr_idle, clk, rst_n, !table_full, replace_ptr_reg == '0, "replace pointer moved before table filled")

endmodule

### tb/nearest_key_position_cache_test.sv
// self-checking testbench for the nearest key position cache: directed and random puts
// and gets under random idling and back-pressure, checked against an in-bench predictor
// depends on nkpc_pkg and the nearest_key_position_cache top level
`timescale 1ns / 1ps

module nearest_key_position_cache_test;
    import nkpc_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef struct packed {
        logic                    op;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
    } cache_cmd_t;

    typedef struct packed {
        logic                    found;
        logic signed [KEY_W-1:0] match_time;
        logic [POS_W-1:0]        match_position;
    } cache_hit_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [WIN_W-1:0]        cfg_wr_data = '0;
    logic                    cmd_valid = 1'b0;
    logic                    cmd_stall;
    logic                    cmd = CMD_PUT;
    logic signed [KEY_W-1:0] key_time = '0;
    logic [POS_W-1:0]        file_position = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic                    found;
    logic signed [KEY_W-1:0] match_time;
    logic [POS_W-1:0]        match_position;

    // predictor state
    logic signed [KEY_W-1:0] key_table [TABLE_DEPTH];
    logic [POS_W-1:0]        pos_table [TABLE_DEPTH];
    int                      fill_level = 0;
    int                      replace_slot = 0;
    logic [WIN_W-1:0]        window_setting = WINDOW_RESET;

    cache_cmd_t              queued_commands [$];
    cache_hit_t              awaited_results [$];
    cache_cmd_t              current_cmd = '0;
    logic                    offering = 1'b0;

    logic                    calm = 1'b0;
    logic                    pressure_on = 1'b0;
    logic                    hold_used = 1'b0;
    int                      hold_left = 0;
    int                      cycle_count = 0;
    int                      fail_count = 0;

    logic signed [KEY_W-1:0] cluster_center = '0;
    logic signed [KEY_W-1:0] recent_keys [$];

    nearest_key_position_cache #(
        .CACHE_ENTRIES(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .key_time(key_time),
        .file_position(file_position),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .found(found),
        .match_time(match_time),
        .match_position(match_position)
    );

    always #10 clk = ~clk;

    function automatic cache_hit_t nearest_entry(input logic signed [KEY_W-1:0] query);
        cache_hit_t hit;
        logic       have_lo;
        logic       have_hi;
        int         lo;
        int         hi;
        int         pick;
        longint     below;
        longint     above;
        hit = '0;
        have_lo = 1'b0;
        have_hi = 1'b0;
        lo = 0;
        hi = 0;
        if (fill_level == 0)
            return hit;
        for (int i = 0; i < fill_level; i++)
        begin
            if (key_table[i] <= query)
            begin
                if (!have_lo || key_table[i] > key_table[lo])
                begin
                    lo = i;
                    have_lo = 1'b1;
                end
            end
            else if (!have_hi || key_table[i] < key_table[hi])
            begin
                hi = i;
                have_hi = 1'b1;
            end
        end
        pick = lo;
        if (have_hi)
        begin
            if (!have_lo)
                pick = hi;
            else
            begin
                below = longint'(query) - longint'(key_table[lo]);
                above = longint'(key_table[hi]) - longint'(query);
                if (below > longint'(window_setting) && above < below)
                    pick = hi;
            end
        end
        hit.found = 1'b1;
        hit.match_time = key_table[pick];
        hit.match_position = pos_table[pick];
        return hit;
    endfunction

    task automatic apply_command(input cache_cmd_t c);
        int slot;
        if (c.op == CMD_PUT)
        begin
            if (fill_level < TABLE_DEPTH)
            begin
                slot = fill_level;
                fill_level++;
            end
            else
            begin
                slot = replace_slot;
                replace_slot = (replace_slot + 1) % TABLE_DEPTH;
            end
            key_table[slot] = c.key;
            pos_table[slot] = c.pos;
        end
        else
            awaited_results.push_back(nearest_entry(c.key));
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            offering = 1'b0;
            cmd_valid <= 1'b0;
        end
        else
        begin
            if (offering && !cmd_stall)
            begin
                apply_command(current_cmd);
                offering = 1'b0;
            end
            if (!offering && queued_commands.size() != 0
                && (calm || $urandom_range(99) >= 21))
            begin
                current_cmd = queued_commands.pop_front();
                offering = 1'b1;
            end
            cmd_valid <= offering;
            cmd <= current_cmd.op;
            key_time <= current_cmd.key;
            file_position <= current_cmd.pos;
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (pressure_on && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver and checker
    always @(posedge clk)
    begin
        cache_hit_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        fail_count++;
                    end
                    if (match_time !== want.match_time)
                    begin
                        $error("match_time: expected %0d, got %0d", want.match_time,
                               match_time);
                        fail_count++;
                    end
                    if (match_position !== want.match_position)
                    begin
                        $error("match_position: expected %h, got %h", want.match_position,
                               match_position);
                        fail_count++;
                    end
                end
            end
            result_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < 21);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("nearest_key_position_cache_test: errors");
            $finish;
        end
    end

    task automatic push_cmd(input logic op, input logic signed [KEY_W-1:0] key,
                            input logic [POS_W-1:0] pos);
        cache_cmd_t c;
        c.op = op;
        c.key = key;
        c.pos = pos;
        queued_commands.push_back(c);
    endtask

    function automatic logic signed [KEY_W-1:0] extreme_key();
        case ($urandom_range(3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_MIN + 1;
            default: return KEY_MAX - 1;
        endcase
    endfunction

    task automatic push_random_cmd();
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
        int                      r;
        int                      d;
        r = $urandom_range(99);
        if ($urandom_range(1) == 0)
        begin
            if (r < 70)
                key = cluster_center + ($urandom_range(400000) - 200000);
            else if (r < 80)
                key = extreme_key();
            else
                key = $urandom;
            case ($urandom_range(9))
                0: pos = '0;
                1: pos = POS_MAX;
                default: pos = POS_W'({$urandom, $urandom});
            endcase
            recent_keys.push_back(key);
            if (recent_keys.size() > TABLE_DEPTH)
                void'(recent_keys.pop_front());
            push_cmd(CMD_PUT, key, pos);
        end
        else
        begin
            if (r < 40 && recent_keys.size() != 0)
            begin
                case ($urandom_range(2))
                    0: d = 0;
                    1: d = 16;
                    default: d = 70000;
                endcase
                key = recent_keys[$urandom_range(recent_keys.size() - 1)]
                      + ($urandom_range(2 * d) - d);
            end
            else if (r < 75)
                key = cluster_center + ($urandom_range(400000) - 200000);
            else if (r < 85)
                key = extreme_key();
            else
                key = $urandom;
            push_cmd(CMD_GET, key, POS_W'({$urandom, $urandom}));
        end
    endtask

    task automatic wait_drained();
        while (queued_commands.size() != 0 || offering || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [WIN_W-1:0] win, input int count,
                             input logic want_calm, input logic want_pressure);
        wait_drained();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= win;
        window_setting = win;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        calm = want_calm;
        pressure_on = want_pressure;
        cluster_center = $urandom;
        for (int i = 0; i < count; i++)
            push_random_cmd();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, only upper entries, ties, window edges, key extremes
        push_cmd(CMD_GET, 32'sd0, '0);
        push_cmd(CMD_PUT, 32'sd100, '0);
        push_cmd(CMD_GET, 32'sd50, '0);
        push_cmd(CMD_PUT, 32'sd100, POS_MAX);
        push_cmd(CMD_GET, 32'sd100, POS_MAX);
        push_cmd(CMD_PUT, 32'sd200, 40'h12_3456_789A);
        push_cmd(CMD_GET, 32'sd130, '0);
        push_cmd(CMD_GET, 32'sd180, '0);
        push_cmd(CMD_GET, 32'sd150, '0);
        push_cmd(CMD_GET, 32'sd110, '0);
        push_cmd(CMD_PUT, KEY_MIN, 40'hAA_AAAA_AAAA);
        push_cmd(CMD_PUT, KEY_MAX, 40'h55_5555_5555);
        push_cmd(CMD_GET, KEY_MIN, '0);
        push_cmd(CMD_GET, KEY_MAX, '0);
        push_cmd(CMD_GET, KEY_MAX - 1, '0);
        push_cmd(CMD_GET, KEY_MIN + 5, '0);
        push_cmd(CMD_GET, KEY_MIN + 50, '0);

        run_phase('0, 280, 1'b0, 1'b0);
        run_phase('1, 280, 1'b1, 1'b0);
        run_phase(WIN_W'($urandom), 280, 1'b0, 1'b1);
        run_phase(16'd1, 280, 1'b0, 1'b0);
        run_phase(WINDOW_RESET, 260, 1'b0, 1'b0);
        run_phase(WIN_W'($urandom_range(2000)), 260, 1'b0, 1'b0);

        wait_drained();
        if (fail_count == 0)
            $display("nearest_key_position_cache_test: clean");
        else
            $display("nearest_key_position_cache_test: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/nkpc_pkg.sv
hw/rtl/nkpc_cell.sv
hw/rtl/nkpc_pick.sv
hw/rtl/nearest_key_position_cache.sv
tb/nearest_key_position_cache_test.sv
